>>> rtl/core/bba_pkg.sv
`default_nettype none

package bba_pkg;

  // request kinds on the input stream
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

  // live allocation count limit, a block at this count is skipped
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // reset value of the default block size register
  localparam logic [39:0] DEFAULT_SIZE_RESET = 40'd268435456;

  // slot update kinds sent to the cells
  typedef enum logic {
    CMD_LOAD,
    CMD_DEC
  } cmd_kind_t;

  typedef struct packed {
    logic      en;
    cmd_kind_t kind;
  } cmd_ctl_t;

  // control part of the search token that walks the cell chain
  typedef struct packed {
    logic active;
    logic found;
    logic free_found;
    logic sel_valid;
  } probe_flags_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_BASE,
    ST_PAD,
    ST_FIT,
    ST_COMMIT,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/bba_cell.sv
`default_nettype none

module bba_cell #(
  parameter int IDX = 0,
  parameter int IW  = 4,
  parameter int SW  = 40
) (
  input  logic                  clk,
  input  logic                  rst,
  // request fields, held stable while the token walks
  input  logic [4:0]            req_type,
  input  logic [SW-1:0]         req_size,
  input  logic [IW-1:0]         req_fslot,
  // token from the previous cell
  input  bba_pkg::probe_flags_t in_flags,
  input  logic [IW-1:0]         in_found_idx,
  input  logic [SW-1:0]         in_found_size,
  input  logic [SW-1:0]         in_found_cursor,
  input  logic [15:0]           in_found_count,
  input  logic [IW-1:0]         in_free_idx,
  input  logic [15:0]           in_sel_count,
  // token to the next cell
  output bba_pkg::probe_flags_t out_flags,
  output logic [IW-1:0]         out_found_idx,
  output logic [SW-1:0]         out_found_size,
  output logic [SW-1:0]         out_found_cursor,
  output logic [15:0]           out_found_count,
  output logic [IW-1:0]         out_free_idx,
  output logic [15:0]           out_sel_count,
  // slot update
  input  bba_pkg::cmd_ctl_t     cmd,
  input  logic [IW-1:0]         cmd_idx,
  input  logic [4:0]            cmd_type,
  input  logic [SW-1:0]         cmd_size,
  input  logic [SW-1:0]         cmd_cursor,
  input  logic [15:0]           cmd_count
);
  import bba_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic          valid;
  logic [4:0]    slot_type;
  logic [SW-1:0] size;
  logic [SW-1:0] cursor;
  logic [15:0]   count;
  logic          hit;
  logic          cmd_hit;

  // this slot can serve the request
  assign hit = valid && (slot_type == req_type) && (count != COUNT_MAX) &&
               ((size - cursor) >= req_size);

  assign cmd_hit = cmd.en && (cmd_idx == MY_IDX);

  // valid mark
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd_hit) begin
      case (cmd.kind)
        CMD_LOAD: valid <= 1'b1;
        CMD_DEC:  if (count == 16'd1) valid <= 1'b0;
        default:  valid <= valid;
      endcase
    end
  end

  // slot contents
  always_ff @(posedge clk) begin
    if (cmd_hit) begin
      case (cmd.kind)
        CMD_LOAD: begin
          slot_type <= cmd_type;
          size      <= cmd_size;
          cursor    <= cmd_cursor;
          count     <= cmd_count;
        end
        CMD_DEC: count <= count - 16'd1;
        default: count <= count;
      endcase
    end
  end

  // token control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_flags <= '0;
    end else begin
      out_flags.active     <= in_flags.active;
      out_flags.found      <= in_flags.found | hit;
      out_flags.free_found <= in_flags.free_found | ~valid;
      out_flags.sel_valid  <= (req_fslot == MY_IDX) ? valid : in_flags.sel_valid;
    end
  end

  // token data, first match wins
  always_ff @(posedge clk) begin
    if (!in_flags.found && hit) begin
      out_found_idx    <= MY_IDX;
      out_found_size   <= size;
      out_found_cursor <= cursor;
      out_found_count  <= count;
    end else begin
      out_found_idx    <= in_found_idx;
      out_found_size   <= in_found_size;
      out_found_cursor <= in_found_cursor;
      out_found_count  <= in_found_count;
    end
    out_free_idx  <= (!in_flags.free_found && !valid) ? MY_IDX : in_free_idx;
    out_sel_count <= (req_fslot == MY_IDX) ? count : in_sel_count;
  end

endmodule

`default_nettype wire

>>> rtl/core/block_bump_allocator.sv
`default_nettype none

// Block bump allocator. Each request carries an allocate or a free of a block
// table slot and produces exactly one result. One request is handled at a
// time: a search token walks the row of slot cells one cell per cycle, then a
// short sequencer works out the pad, the fit and the slot update. From
// acceptance to the result register an allocation in a shared block passes
// the launch register, the slot cells and the states SCAN, BASE, PAD, FIT,
// COMMIT and OUT; one that falls back to a dedicated block skips COMMIT, and
// a free or a table found full at BASE goes from BASE straight to OUT.
// The result is loaded only once the previous result has been taken, so a
// stalled consumer lengthens this path. The input is accepted again in the
// cycle after the result is registered, even while that result waits for
// the consumer. Configuration writes to the default block size take effect
// for the next request and must only be made while the block is idle.
module block_bump_allocator #(
  parameter int NUM_SLOTS = 16,
  parameter int SIZE_BITS = 40
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // memory_type, request_size, align_log2, free_slot
  input  logic        s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // block_slot, offset, created_size, released
  output logic [1:0]  m_tuser,   // status
  input  logic        cfg_wr_en,
  input  logic [39:0] cfg_wr_data
);
  import bba_pkg::*;

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int SW = SIZE_BITS;
  localparam int CW = (SIZE_BITS > 32) ? SIZE_BITS : 32;
  localparam int AW = CW + 1;

  state_t state, state_next;

  // configuration
  logic [SW-1:0] dflt;

  // request registers
  logic          launch;
  logic          op_r;
  logic [4:0]    type_r;
  logic [SW-1:0] req_r;
  logic [4:0]    align_r;
  logic [3:0]    fslot_r;
  logic [IW-1:0] fslot_idx;
  logic          fslot_ok;

  // cell chain
  probe_flags_t  pf     [NUM_SLOTS+1];
  logic [IW-1:0] p_fidx [NUM_SLOTS+1];
  logic [SW-1:0] p_fsize[NUM_SLOTS+1];
  logic [SW-1:0] p_fcur [NUM_SLOTS+1];
  logic [15:0]   p_fcnt [NUM_SLOTS+1];
  logic [IW-1:0] p_eidx [NUM_SLOTS+1];
  logic [15:0]   p_scnt [NUM_SLOTS+1];

  // captured search results
  probe_flags_t  cap_flags;
  logic [IW-1:0] cap_fidx;
  logic [SW-1:0] cap_fsize;
  logic [SW-1:0] cap_fcur;
  logic [15:0]   cap_fcnt;
  logic [IW-1:0] cap_eidx;
  logic [15:0]   cap_scnt;

  // chosen block
  logic [IW-1:0] b_idx;
  logic [SW-1:0] b_size;
  logic [SW-1:0] b_cur;
  logic [15:0]   b_cnt;
  logic [SW-1:0] created_r;
  logic [SW-1:0] new_size;

  // alignment
  logic [AW-1:0] align_w;
  logic [AW-1:0] low_w;
  logic [AW-1:0] pad_w;
  logic [AW-1:0] pad_r;
  logic [SW-1:0] rem_r;
  logic [SW-1:0] off_r;
  logic [AW-1:0] rem_w;
  logic [AW-1:0] req_w;
  logic          fits;

  // slot update
  cmd_ctl_t      cmd;
  logic [IW-1:0] cmd_idx;
  logic [4:0]    cmd_type;
  logic [SW-1:0] cmd_size;
  logic [SW-1:0] cmd_cursor;
  logic [15:0]   cmd_count;

  // pending result
  logic          res_load;
  logic [1:0]    res_status_next;
  logic [IW-1:0] res_slot_next;
  logic [SW-1:0] res_off_next;
  logic [SW-1:0] res_created_next;
  logic          res_released_next;
  logic [1:0]    res_status;
  logic [IW-1:0] res_slot;
  logic [SW-1:0] res_off;
  logic [SW-1:0] res_created;
  logic          res_released;
  logic          out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  assign fslot_idx = IW'(fslot_r);
  assign fslot_ok  = (9'(fslot_r) < 9'(NUM_SLOTS));

  // default block size register
  always_ff @(posedge clk) begin
    if (rst) begin
      dflt <= SW'(DEFAULT_SIZE_RESET);
    end else if (cfg_wr_en) begin
      dflt <= SW'(cfg_wr_data);
    end
  end

  // token launch in the cycle after acceptance
  always_ff @(posedge clk) begin
    if (rst) begin
      launch <= 1'b0;
    end else begin
      launch <= s_tvalid && s_tready;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_r    <= s_tuser;
      type_r  <= s_tdata[4:0];
      req_r   <= SW'(s_tdata[44:5]);
      align_r <= s_tdata[49:45];
      fslot_r <= s_tdata[53:50];
    end
  end

  // head of the chain
  assign pf[0]      = '{active: launch, found: 1'b0, free_found: 1'b0, sel_valid: 1'b0};
  assign p_fidx[0]  = '0;
  assign p_fsize[0] = '0;
  assign p_fcur[0]  = '0;
  assign p_fcnt[0]  = '0;
  assign p_eidx[0]  = '0;
  assign p_scnt[0]  = '0;

  // row of slot cells
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    bba_cell #(
      .IDX (i),
      .IW  (IW),
      .SW  (SW)
    ) u_cell (
      .clk              (clk),
      .rst              (rst),
      .req_type         (type_r),
      .req_size         (req_r),
      .req_fslot        (fslot_idx),
      .in_flags         (pf[i]),
      .in_found_idx     (p_fidx[i]),
      .in_found_size    (p_fsize[i]),
      .in_found_cursor  (p_fcur[i]),
      .in_found_count   (p_fcnt[i]),
      .in_free_idx      (p_eidx[i]),
      .in_sel_count     (p_scnt[i]),
      .out_flags        (pf[i+1]),
      .out_found_idx    (p_fidx[i+1]),
      .out_found_size   (p_fsize[i+1]),
      .out_found_cursor (p_fcur[i+1]),
      .out_found_count  (p_fcnt[i+1]),
      .out_free_idx     (p_eidx[i+1]),
      .out_sel_count    (p_scnt[i+1]),
      .cmd              (cmd),
      .cmd_idx          (cmd_idx),
      .cmd_type         (cmd_type),
      .cmd_size         (cmd_size),
      .cmd_cursor       (cmd_cursor),
      .cmd_count        (cmd_count)
    );
  end

  // capture the token at the end of the chain
  always_ff @(posedge clk) begin
    if (state == ST_SCAN && pf[NUM_SLOTS].active) begin
      cap_flags <= pf[NUM_SLOTS];
      cap_fidx  <= p_fidx[NUM_SLOTS];
      cap_fsize <= p_fsize[NUM_SLOTS];
      cap_fcur  <= p_fcur[NUM_SLOTS];
      cap_fcnt  <= p_fcnt[NUM_SLOTS];
      cap_eidx  <= p_eidx[NUM_SLOTS];
      cap_scnt  <= p_scnt[NUM_SLOTS];
    end
  end

  // size of a new shared block
  assign new_size = (req_r > dflt) ? req_r : dflt;

  // base block selection
  always_ff @(posedge clk) begin
    if (state == ST_BASE) begin
      if (cap_flags.found) begin
        b_idx     <= cap_fidx;
        b_size    <= cap_fsize;
        b_cur     <= cap_fcur;
        b_cnt     <= cap_fcnt;
        created_r <= '0;
      end else begin
        b_idx     <= cap_eidx;
        b_size    <= new_size;
        b_cur     <= '0;
        b_cnt     <= '0;
        created_r <= new_size;
      end
    end
  end

  // pad to the requested alignment
  assign align_w = AW'(1) << align_r;
  assign low_w   = AW'(b_cur) & (align_w - AW'(1));
  assign pad_w   = (low_w != '0) ? (align_w - low_w) : '0;

  always_ff @(posedge clk) begin
    if (state == ST_PAD) begin
      rem_r <= b_size - b_cur;
      pad_r <= pad_w;
    end
  end

  // fit check and aligned offset
  assign rem_w = AW'(rem_r);
  assign req_w = AW'(req_r);
  assign fits  = (pad_r <= rem_w) && ((rem_w - pad_r) >= req_w);

  always_ff @(posedge clk) begin
    if (state == ST_FIT) begin
      off_r <= SW'(AW'(b_cur) + pad_r);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_SCAN;
      ST_SCAN:   if (pf[NUM_SLOTS].active) state_next = ST_BASE;
      ST_BASE: begin
        if (op_r == OP_FREE) begin
          state_next = ST_OUT;
        end else if (cap_flags.found || cap_flags.free_found) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_PAD:    state_next = ST_FIT;
      ST_FIT:    state_next = fits ? ST_COMMIT : ST_OUT;
      ST_COMMIT: state_next = ST_OUT;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // slot updates and result values
  always_comb begin
    cmd               = '{en: 1'b0, kind: CMD_LOAD};
    cmd_idx           = '0;
    cmd_type          = type_r;
    cmd_size          = '0;
    cmd_cursor        = '0;
    cmd_count         = '0;
    res_load          = 1'b0;
    res_status_next   = STATUS_OK;
    res_slot_next     = '0;
    res_off_next      = '0;
    res_created_next  = '0;
    res_released_next = 1'b0;
    case (state)
      ST_BASE: begin
        if (op_r == OP_FREE) begin
          res_load = 1'b1;
          if (!fslot_ok || !cap_flags.sel_valid) begin
            res_status_next = STATUS_BAD_FREE;
          end else begin
            cmd               = '{en: 1'b1, kind: CMD_DEC};
            cmd_idx           = fslot_idx;
            res_slot_next     = fslot_idx;
            res_released_next = ((cap_scnt - 16'd1) == 16'd0);
          end
        end else if (!cap_flags.found && !cap_flags.free_found) begin
          res_load        = 1'b1;
          res_status_next = STATUS_FULL;
        end
      end
      ST_FIT: begin
        // dedicated block when the aligned request misses the found block
        if (!fits) begin
          res_load = 1'b1;
          if (cap_flags.free_found) begin
            cmd              = '{en: 1'b1, kind: CMD_LOAD};
            cmd_idx          = cap_eidx;
            cmd_size         = req_r;
            cmd_cursor       = req_r;
            cmd_count        = 16'd1;
            res_slot_next    = cap_eidx;
            res_created_next = req_r;
          end else begin
            res_status_next = STATUS_FULL;
          end
        end
      end
      ST_COMMIT: begin
        cmd              = '{en: 1'b1, kind: CMD_LOAD};
        cmd_idx          = b_idx;
        cmd_size         = b_size;
        cmd_cursor       = off_r + req_r;
        cmd_count        = b_cnt + 16'd1;
        res_load         = 1'b1;
        res_slot_next    = b_idx;
        res_off_next     = off_r;
        res_created_next = created_r;
      end
      default: res_load = 1'b0;
    endcase
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_status   <= res_status_next;
      res_slot     <= res_slot_next;
      res_off      <= res_off_next;
      res_created  <= res_created_next;
      res_released <= res_released_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_tuser         <= res_status;
      m_tdata[3:0]    <= 4'(res_slot);
      m_tdata[43:4]   <= 40'(res_off);
      m_tdata[83:44]  <= 40'(res_created);
      m_tdata[84]     <= res_released;
      m_tdata[87:85]  <= 3'd0;
    end
  end

endmodule

`default_nettype wire
